// ----- sv/wv1d_pkg.sv -----
// Shared constants, codes and helpers for the 1-D wave equation stepper.
`default_nettype none

package wv1d_pkg;

    localparam int MAX_POINTS = 32;
    localparam int MIN_POINTS = 3;
    localparam int FRAC_BITS  = 16;

    localparam int DATA_W  = 32;
    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int CSQ_W   = 18;
    localparam int NPTS_W  = 6;
    localparam int LVL_W   = 16;
    localparam int LAP_W   = DATA_W + 3;
    localparam int PROD_W  = LAP_W + CSQ_W + 1;
    localparam int SUM_W   = DATA_W + 8;
    localparam int ADDR_W  = 3;
    localparam int PDATA_W = 32;

    localparam logic [CSQ_W-1:0]  CSQ_RESET  = CSQ_W'(16384);
    localparam logic [NPTS_W-1:0] NPTS_RESET = NPTS_W'(5);
    localparam logic [LVL_W-1:0]  LVL_MAX    = '1;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Register select, taken from paddr[2]
    localparam logic REG_COURANT = 1'b0;
    localparam logic REG_NPTS    = 1'b1;

    // Clamp the configured grid size to the supported range.
    function automatic logic [CNT_W-1:0] npts_clamp(input logic [NPTS_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (int'(v) < MIN_POINTS)
            r = CNT_W'(MIN_POINTS);
        else if (int'(v) > MAX_POINTS)
            r = CNT_W'(MAX_POINTS);
        else
            r = CNT_W'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/wave_1d_explicit_stepper_core.sv -----
// Top level: explicit finite-difference stepper for the 1-D wave equation.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  request   | start / busy         | cmd, position, sample
//  result    | strobe (one cycle)   | time_level, point, displacement, last
//  config    | APB psel/penable     | paddr, pwdata, prdata (courant_sq, num_points)
//
// A load request writes the row memory directly and busy stays low. A step
// request sweeps the row through one shared lap/multiply/accumulate pipeline
// at one point a cycle; it holds busy until the last point has been computed,
// reading from the single read port of each row memory into the pipeline.
// The result receiver cannot stall; results leave one per cycle. Reset clears
// the control state and the time counter; row memories are not cleared.
`default_nettype none

module wave_1d_explicit_stepper_core
    import wv1d_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // request channel
    input  wire logic                     start,
    output      logic                     busy,
    input  wire logic                     cmd,
    input  wire logic [4:0]               position,
    input  wire logic signed [DATA_W-1:0] sample,
    // result channel
    output      logic                     strobe,
    output      logic [LVL_W-1:0]         time_level,
    output      logic [4:0]               point,
    output      logic signed [DATA_W-1:0] displacement,
    output      logic                     last,
    // configuration
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_W-1:0]        paddr,
    input  wire logic [PDATA_W-1:0]       pwdata,
    output      logic [PDATA_W-1:0]       prdata,
    output      logic                     pready
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // configuration registers
    logic [CSQ_W-1:0]  csq_reg;
    logic [NPTS_W-1:0] npts_cfg_reg;

    // sequencer
    logic              state_reg, state_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]  npts_reg;
    logic [LVL_W-1:0]  step_cnt_reg, step_cnt_next;
    logic              first_reg;

    // row memories
    logic signed [DATA_W-1:0] cur_mem  [MAX_POINTS];
    logic signed [DATA_W-1:0] prev_mem [MAX_POINTS];
    logic signed [DATA_W-1:0] cur_rd_reg, prev_rd_reg;
    logic                     cur_we;
    logic [IDX_W-1:0]         cur_wa;
    logic signed [DATA_W-1:0] cur_wd;

    // pipeline
    logic                     s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [CNT_W-1:0]         s1_idx_reg;
    logic signed [DATA_W-1:0] up1_reg, u0_reg, p1_reg;
    logic signed [LAP_W-1:0]  lap_reg;
    logic signed [DATA_W-1:0] u2_reg, p2_reg, u3_reg, p3_reg;
    logic [IDX_W-1:0]         i2_reg, i3_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // output registers
    logic                     strobe_reg, last_reg;
    logic [LVL_W-1:0]         lvl_reg;
    logic [IDX_W-1:0]         point_reg;
    logic signed [DATA_W-1:0] disp_reg;

    logic                     accept, load_acc, step_acc, issue, cfg_wr, row_done;
    logic [CNT_W-1:0]         npts_m1;
    logic [CNT_W-1:0]         s1_center;
    logic signed [LAP_W-1:0]  lap_calc;
    logic signed [PROD_W-1:0] prod_sh_first, prod_sh_next;
    logic signed [SUM_W-1:0]  u3_ext, p3_ext, sum_first, sum_next, sum_sel;
    logic signed [DATA_W-1:0] sat_val, res_val;
    logic                     is_edge;

    assign busy     = (state_reg == ST_RUN);
    assign accept   = start && !busy;
    assign load_acc = accept && (cmd == CMD_LOAD);
    assign step_acc = accept && (cmd == CMD_STEP);
    assign issue    = (state_reg == ST_RUN) && (rd_idx_reg <= npts_reg);
    assign npts_m1  = CNT_W'(npts_reg - 1'b1);
    assign row_done = s3_vld_reg && (i3_reg == npts_m1[IDX_W-1:0]);

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_COURANT: prdata = PDATA_W'(csq_reg);
            REG_NPTS:    prdata = PDATA_W'(npts_cfg_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csq_reg      <= CSQ_RESET;
            npts_cfg_reg <= NPTS_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_COURANT: csq_reg      <= pwdata[CSQ_W-1:0];
                REG_NPTS:    npts_cfg_reg <= pwdata[NPTS_W-1:0];
                default:     ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next    = state_reg;
        rd_idx_next   = rd_idx_reg;
        step_cnt_next = step_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load_acc)
                    step_cnt_next = '0;
                else if (step_acc)
                begin
                    state_next  = ST_RUN;
                    rd_idx_next = '0;
                    if (step_cnt_reg != LVL_MAX)
                        step_cnt_next = step_cnt_reg + 1'b1;
                end
            end
            ST_RUN:
            begin
                if (issue)
                    rd_idx_next = rd_idx_reg + 1'b1;
                if (row_done)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_idx_reg   <= '0;
            step_cnt_reg <= '0;
            npts_reg     <= CNT_W'(MIN_POINTS);
            first_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_idx_reg   <= rd_idx_next;
            step_cnt_reg <= step_cnt_next;
            if (step_acc)
            begin
                npts_reg  <= npts_clamp(npts_cfg_reg);
                first_reg <= (step_cnt_reg == '0);
            end
        end
    end

    // ---------------- row memories ----------------
    always_comb
    begin
        if (load_acc)
        begin
            cur_we = 1'b1;
            cur_wa = IDX_W'(position);
            cur_wd = sample;
        end
        else
        begin
            cur_we = s3_vld_reg;
            cur_wa = i3_reg;
            cur_wd = res_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cur_we)
            cur_mem[cur_wa] <= cur_wd;
        cur_rd_reg <= cur_mem[rd_idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (s3_vld_reg)
            prev_mem[i3_reg] <= u3_reg;
        prev_rd_reg <= prev_mem[rd_idx_reg[IDX_W-1:0]];
    end

    // ---------------- shared datapath ----------------
    // Window before the shift holds cur[k-1], cur[k-2]; read data is cur[k].
    assign lap_calc = LAP_W'(cur_rd_reg) - (LAP_W'(up1_reg) <<< 1) + LAP_W'(u0_reg);
    assign s1_center = CNT_W'(s1_idx_reg - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= issue;
            s2_vld_reg <= s1_vld_reg && (s1_idx_reg != '0);
            s3_vld_reg <= s2_vld_reg;
            strobe_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= rd_idx_reg;
        if (s1_vld_reg)
        begin
            up1_reg <= cur_rd_reg;
            u0_reg  <= up1_reg;
            p1_reg  <= prev_rd_reg;
            lap_reg <= lap_calc;
            u2_reg  <= up1_reg;
            p2_reg  <= p1_reg;
            i2_reg  <= s1_center[IDX_W-1:0];
        end
        prod_reg <= PROD_W'(lap_reg * $signed({1'b0, csq_reg}));
        u3_reg   <= u2_reg;
        p3_reg   <= p2_reg;
        i3_reg   <= i2_reg;
    end

    // Arithmetic shift gives floor division by a power of two.
    assign prod_sh_first = prod_reg >>> (FRAC_BITS + 1);
    assign prod_sh_next  = prod_reg >>> FRAC_BITS;
    assign u3_ext        = SUM_W'(u3_reg);
    assign p3_ext        = SUM_W'(p3_reg);
    assign sum_first     = u3_ext + prod_sh_first[SUM_W-1:0];
    assign sum_next      = (u3_ext <<< 1) - p3_ext + prod_sh_next[SUM_W-1:0];
    assign sum_sel       = first_reg ? sum_first : sum_next;

    always_comb
    begin
        if (sum_sel[SUM_W-1:DATA_W-1] == '0 || sum_sel[SUM_W-1:DATA_W-1] == '1)
            sat_val = sum_sel[DATA_W-1:0];
        else if (sum_sel[SUM_W-1])
            sat_val = {1'b1, {(DATA_W-1){1'b0}}};
        else
            sat_val = {1'b0, {(DATA_W-1){1'b1}}};
    end

    // Force both end points to zero.
    assign is_edge = (i3_reg == '0) || (i3_reg == npts_m1[IDX_W-1:0]);
    assign res_val = is_edge ? '0 : sat_val;

    always_ff @(posedge clk)
    begin
        lvl_reg   <= step_cnt_reg;
        point_reg <= i3_reg;
        disp_reg  <= res_val;
        last_reg  <= row_done;
    end

    assign strobe       = strobe_reg;
    assign time_level   = lvl_reg;
    assign point        = point_reg;
    assign displacement = disp_reg;
    assign last         = last_reg;

    // ---------------- assertions ----------------
    a_mid_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("result mid-row while sequencer idle");

    a_step_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd == CMD_STEP |=> busy)
        else $error("step request did not start the sweep");

    a_last_point: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> point == npts_m1[IDX_W-1:0])
        else $error("last flag on wrong grid point");

    a_level_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> time_level != '0)
        else $error("row emitted with zero time level");

endmodule

`default_nettype wire

// ----- tb/wave_1d_explicit_stepper_core_tb.sv -----
// Self-checking testbench for the 1-D wave equation stepper core.
`default_nettype none

module wave_1d_explicit_stepper_core_tb;
    import wv1d_pkg::*;

    localparam int RANDOM_ITEMS   = 390;
    localparam int PHASE_ITEMS    = 80;
    localparam int SETTLE_CYCLES  = MAX_POINTS + 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PLAN_LEN       = 22;

    localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [LVL_W-1:0]         level;
        logic [4:0]               pt;
        logic signed [DATA_W-1:0] value;
        logic                     fin;
    } row_result_t;

    typedef enum logic [1:0] {ROW_REQ, ROW_TYPED, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic                     op;
        logic [4:0]               pos;
        logic signed [DATA_W-1:0] value;
        int                       reps;
        logic [LVL_W-1:0]         want_level;
        logic signed [DATA_W-1:0] want_mid;
        logic [CSQ_W-1:0]         csq;
        logic [NPTS_W-1:0]        npts;
    } plan_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     cmd = CMD_LOAD;
    logic [4:0]               position = '0;
    logic signed [DATA_W-1:0] sample = '0;
    logic                     strobe;
    logic [LVL_W-1:0]         time_level;
    logic [4:0]               point;
    logic signed [DATA_W-1:0] displacement;
    logic                     last;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [PDATA_W-1:0]       pwdata = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;

    wave_1d_explicit_stepper_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .position     (position),
        .sample       (sample),
        .strobe       (strobe),
        .time_level   (time_level),
        .point        (point),
        .displacement (displacement),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state
    logic signed [DATA_W-1:0] cur_row   [MAX_POINTS];
    logic signed [DATA_W-1:0] prior_row [MAX_POINTS];
    bit                       cur_written   [MAX_POINTS];
    bit                       prior_written [MAX_POINTS];
    logic [LVL_W-1:0]         level_count = '0;
    logic [CSQ_W-1:0]         shadow_csq  = CSQ_RESET;
    logic [NPTS_W-1:0]        shadow_npts = NPTS_RESET;
    row_result_t              level_out [MAX_POINTS];
    int                       level_len;

    row_result_t pending_rows [$];
    plan_row_t   plan [PLAN_LEN];
    int          fail_count = 0;
    int          quiet_cycles = 0;
    bit          no_gaps = 1'b0;

    function automatic int points_active();
        if (shadow_npts < NPTS_W'(MIN_POINTS))
            return MIN_POINTS;
        if (shadow_npts > NPTS_W'(MAX_POINTS))
            return MAX_POINTS;
        return int'(shadow_npts);
    endfunction

    function automatic logic signed [DATA_W-1:0] clip_word(input longint v);
        if (v > longint'(S_MAX))
            return S_MAX;
        if (v < longint'(S_MIN))
            return S_MIN;
        return DATA_W'(v);
    endfunction

    // Compute the next time level into level_out and roll the rows.
    task automatic advance_level();
        int                       n;
        int                       i;
        bit                       fresh;
        logic signed [DATA_W-1:0] nxt [MAX_POINTS];
        longint                   u;
        longint                   lap;
        longint                   prod;
        longint                   v;
        n = points_active();
        fresh = (level_count == '0);
        for (i = 0; i < MAX_POINTS; i++)
            nxt[i] = '0;
        for (i = 1; i + 1 < n; i++)
        begin
            u    = longint'(cur_row[i]);
            lap  = longint'(cur_row[i + 1]) - 2 * u + longint'(cur_row[i - 1]);
            prod = lap * longint'(shadow_csq);
            if (fresh)
                v = u + (prod >>> (FRAC_BITS + 1));
            else
                v = 2 * u - longint'(prior_row[i]) + (prod >>> FRAC_BITS);
            nxt[i] = clip_word(v);
        end
        for (i = 0; i < n; i++)
        begin
            prior_row[i]     = cur_row[i];
            prior_written[i] = cur_written[i];
            cur_row[i]       = nxt[i];
            cur_written[i]   = 1'b1;
        end
        if (level_count != LVL_MAX)
            level_count++;
        for (i = 0; i < n; i++)
            level_out[i] = '{level_count, 5'(i), nxt[i], (i == n - 1)};
        level_len = n;
    endtask

    // Never step over a row entry that has not been written yet.
    function automatic bit step_is_safe();
        int i;
        for (i = 0; i < points_active(); i++)
            if (!cur_written[i] || (level_count != '0 && !prior_written[i]))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            case ($urandom_range(0, 3))
                0:       return S_MAX;
                1:       return S_MIN;
                2:       return '0;
                default: return -1;
            endcase
        end
        if (r < 50)
            return DATA_W'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        return DATA_W'($urandom);
    endfunction

    task automatic note_failure();
        fail_count++;
    endtask

    // The block is idle on entry, so the first edge accepts the request.
    task automatic send_request(input logic op, input logic [4:0] pos,
                                input logic signed [DATA_W-1:0] value, input bit own_expect);
        int i;
        if (!no_gaps && $urandom_range(0, 99) < 17)
        begin
            start <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(9, 40)) @(posedge clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        start    <= 1'b1;
        cmd      <= op;
        position <= pos;
        sample   <= value;
        @(posedge clk);
        if (op == CMD_LOAD)
        begin
            cur_row[pos]     = value;
            cur_written[pos] = 1'b1;
            level_count      = '0;
        end
        else
        begin
            advance_level();
            if (!own_expect)
                for (i = 0; i < level_len; i++)
                    pending_rows.push_back(level_out[i]);
        end
        while (busy)
            @(posedge clk);
    endtask

    // Drop start, drain the results and let the pipeline empty.
    task automatic settle();
        start <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic sel, input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {sel, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register(input logic sel);
        logic [PDATA_W-1:0] got;
        logic [PDATA_W-1:0] want;
        apb_access(1'b0, sel, '0, got);
        want = (sel == REG_NPTS) ? PDATA_W'(shadow_npts) : PDATA_W'(shadow_csq);
        if (got !== want)
        begin
            note_failure();
            if (fail_count <= 10)
                $display("register %0d readback: expected %0d, got %0d", sel, want, got);
        end
    endtask

    task automatic program_register(input logic sel, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] unused;
        apb_access(1'b1, sel, value, unused);
        if (sel == REG_COURANT)
            shadow_csq = value[CSQ_W-1:0];
        else
            shadow_npts = value[NPTS_W-1:0];
        check_register(sel);
    endtask

    always @(posedge clk)
    begin : result_check
        row_result_t seen;
        row_result_t want;
        if (rst_n && strobe)
        begin
            seen = '{time_level, point, displacement, last};
            if (pending_rows.size() == 0)
            begin
                note_failure();
                if (fail_count <= 10)
                    $display("unexpected result: level %0d point %0d value %0d last %0b",
                             seen.level, seen.pt, seen.value, seen.fin);
            end
            else
            begin
                want = pending_rows.pop_front();
                if (seen !== want)
                begin
                    note_failure();
                    if (fail_count <= 10)
                        $display({"result mismatch: expected level %0d point %0d value %0d ",
                                  "last %0b, got level %0d point %0d value %0d last %0b"},
                                 want.level, want.pt, want.value, want.fin,
                                 seen.level, seen.pt, seen.value, seen.fin);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int  k;
        int  i;
        int  n;
        int  gap;
        int  pick;
        plan = '{
            '{ROW_REQ,   CMD_LOAD, 5'd0,  S_MAX,          5,     16'd0, 32'sd0, '0, '0},
            '{ROW_TYPED, CMD_STEP, 5'd0,  32'sd0,         1,     16'd1, S_MAX,  '0, '0},
            '{ROW_REQ,   CMD_STEP, 5'd0,  32'sd0,         2,     16'd0, 32'sd0, '0, '0},
            '{ROW_REQ,   CMD_LOAD, 5'd0,  S_MIN,          5,     16'd0, 32'sd0, '0, '0},
            '{ROW_TYPED, CMD_STEP, 5'd0,  32'sd0,         1,     16'd1, S_MIN,  '0, '0},
            '{ROW_REQ,   CMD_STEP, 5'd0,  32'sd0,         3,     16'd0, 32'sd0, '0, '0},
            // Courant above one on the smallest grid
            '{ROW_CFG,   CMD_LOAD, 5'd0,  32'sd0,         0,     16'd0, 32'sd0,
              18'd131072, 6'd3},
            '{ROW_REQ,   CMD_LOAD, 5'd0,  32'sd0,         3,     16'd0, 32'sd0, '0, '0},
            '{ROW_REQ,   CMD_LOAD, 5'd1,  S_MAX,          1,     16'd0, 32'sd0, '0, '0},
            '{ROW_REQ,   CMD_STEP, 5'd0,  32'sd0,         4,     16'd0, 32'sd0, '0, '0},
            // Grid size below range, zero Courant
            '{ROW_CFG,   CMD_LOAD, 5'd0,  32'sd0,         0,     16'd0, 32'sd0, 18'd0, 6'd0},
            '{ROW_REQ,   CMD_LOAD, 5'd0,  32'sh0001_0000, 3,     16'd0, 32'sd0, '0, '0},
            '{ROW_TYPED, CMD_STEP, 5'd0,  32'sd0,         1,     16'd1, 32'sh0001_0000,
              '0, '0},
            // Keep stepping with zero Courant
            '{ROW_REQ,   CMD_STEP, 5'd0,  32'sd0,         4,     16'd0, 32'sd0, '0, '0},
            // Grid size above range
            '{ROW_CFG,   CMD_LOAD, 5'd0,  32'sd0,         0,     16'd0, 32'sd0,
              18'd65536, 6'd63},
            '{ROW_REQ,   CMD_LOAD, 5'd0,  32'sh1234_5678, 32,    16'd0, 32'sd0, '0, '0},
            '{ROW_TYPED, CMD_STEP, 5'd0,  32'sd0,         1,     16'd1, 32'sh1234_5678,
              '0, '0},
            '{ROW_REQ,   CMD_LOAD, 5'd31, 32'shEDCB_A987, 1,     16'd0, 32'sd0, '0, '0},
            '{ROW_REQ,   CMD_LOAD, 5'd17, 32'shA5A5_A5A5, 1,     16'd0, 32'sd0, '0, '0},
            '{ROW_REQ,   CMD_STEP, 5'd0,  32'sd0,         2,     16'd0, 32'sd0, '0, '0},
            '{ROW_CFG,   CMD_LOAD, 5'd0,  32'sd0,         0,     16'd0, 32'sd0,
              18'h3FFFF, 6'd32},
            '{ROW_REQ,   CMD_STEP, 5'd0,  32'sd0,         2,     16'd0, 32'sd0, '0, '0}
        };
        for (i = 0; i < MAX_POINTS; i++)
        begin
            cur_row[i]       = '0;
            prior_row[i]     = '0;
            cur_written[i]   = 1'b0;
            prior_written[i] = 1'b0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        check_register(REG_COURANT);
        check_register(REG_NPTS);

        foreach (plan[r])
        begin
            case (plan[r].kind)
                ROW_CFG:
                begin
                    settle();
                    program_register(REG_COURANT, PDATA_W'(plan[r].csq));
                    program_register(REG_NPTS, PDATA_W'(plan[r].npts));
                end
                ROW_TYPED:
                begin
                    // Queue the typed row before the sweep starts emitting it.
                    n = points_active();
                    for (i = 0; i < n; i++)
                        pending_rows.push_back('{plan[r].want_level, 5'(i),
                            (i == 0 || i == n - 1) ? 32'sd0 : plan[r].want_mid,
                            (i == n - 1)});
                    send_request(CMD_STEP, '0, '0, 1'b1);
                end
                default:
                begin
                    no_gaps = (plan[r].reps > 100);
                    for (k = 0; k < plan[r].reps; k++)
                        send_request(plan[r].op, plan[r].pos + 5'(k), plan[r].value, 1'b0);
                    no_gaps = 1'b0;
                end
            endcase
        end

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % PHASE_ITEMS == 0)
            begin
                settle();
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    program_register(REG_COURANT, 0);
                else if (pick < 30)
                    program_register(REG_COURANT, 131072);
                else if (pick < 40)
                    program_register(REG_COURANT, (1 << CSQ_W) - 1);
                else if (pick < 60)
                    program_register(REG_COURANT, 65536);
                else
                    program_register(REG_COURANT, $urandom_range(0, 131072));
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    program_register(REG_NPTS, MIN_POINTS);
                else if (pick < 30)
                    program_register(REG_NPTS, MAX_POINTS);
                else if (pick < 40)
                    program_register(REG_NPTS, $urandom_range(0, MIN_POINTS - 1));
                else if (pick < 50)
                    program_register(REG_NPTS, $urandom_range(MAX_POINTS + 1, 63));
                else
                    program_register(REG_NPTS, $urandom_range(MIN_POINTS, MAX_POINTS));
            end
            no_gaps = (k >= 200 && k < 300);
            n = points_active();
            gap = -1;
            for (i = n - 1; i >= 0; i--)
                if (!cur_written[i])
                    gap = i;
            pick = $urandom_range(0, 99);
            if (gap >= 0)
                send_request(CMD_LOAD, 5'(gap), pick_sample(), 1'b0);
            else if (!step_is_safe())
                send_request(CMD_LOAD, 5'($urandom_range(0, n - 1)), pick_sample(), 1'b0);
            else if (pick < 60)
                send_request(CMD_STEP, 5'($urandom), DATA_W'($urandom), 1'b0);
            else if (pick < 88)
                send_request(CMD_LOAD, 5'($urandom_range(0, n - 1)), pick_sample(), 1'b0);
            else
                send_request(CMD_LOAD, 5'($urandom_range(0, 31)), pick_sample(), 1'b0);
        end
        no_gaps = 1'b0;

        settle();
        if (fail_count == 0 && pending_rows.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ----- wave_1d_explicit_stepper_core.f -----
sv/wv1d_pkg.sv
sv/wave_1d_explicit_stepper_core.sv
tb/wave_1d_explicit_stepper_core_tb.sv
